// ===== rtl/rvalu_pkg.sv =====
// rvalu_pkg: operation codes, pipeline constants and shared types of the execute unit
`default_nettype none
package rvalu_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned MODE_W    = 5;
   localparam int unsigned DIV_STEPS = XLEN;
   // operand register with multiply partials, product and simple operations, divider load,
   // divider steps, output
   localparam int unsigned LATENCY   = 4 + DIV_STEPS;

   localparam logic [MODE_W-1:0] MODE_ADD    = 5'd0;
   localparam logic [MODE_W-1:0] MODE_SUB    = 5'd1;
   localparam logic [MODE_W-1:0] MODE_SLL    = 5'd2;
   localparam logic [MODE_W-1:0] MODE_SLT    = 5'd3;
   localparam logic [MODE_W-1:0] MODE_SLTU   = 5'd4;
   localparam logic [MODE_W-1:0] MODE_XOR    = 5'd5;
   localparam logic [MODE_W-1:0] MODE_SRL    = 5'd6;
   localparam logic [MODE_W-1:0] MODE_SRA    = 5'd7;
   localparam logic [MODE_W-1:0] MODE_OR     = 5'd8;
   localparam logic [MODE_W-1:0] MODE_AND    = 5'd9;
   localparam logic [MODE_W-1:0] MODE_MUL    = 5'd10;
   localparam logic [MODE_W-1:0] MODE_MULH   = 5'd11;
   localparam logic [MODE_W-1:0] MODE_MULHSU = 5'd12;
   localparam logic [MODE_W-1:0] MODE_MULHU  = 5'd13;
   localparam logic [MODE_W-1:0] MODE_DIV    = 5'd14;
   localparam logic [MODE_W-1:0] MODE_DIVU   = 5'd15;
   localparam logic [MODE_W-1:0] MODE_REM    = 5'd16;
   localparam logic [MODE_W-1:0] MODE_REMU   = 5'd17;

   localparam logic [XLEN-1:0] WORD_ONES = 32'hFFFF_FFFF;
   localparam logic [XLEN-1:0] SIGN_BIT  = 32'h8000_0000;

   typedef logic [XLEN-1:0]   word_type;
   typedef logic [MODE_W-1:0] mode_type;

   // side information that travels with an item through the divider
   typedef struct packed {
      mode_type mode;
      logic     neg_q;
      logic     neg_r;
      logic     spec;
      word_type spec_val;
      word_type side;
   } div_tag_type;

   // working registers of one divider step
   typedef struct packed {
      word_type n;
      word_type r;
      word_type d;
   } div_work_type;

endpackage
`default_nettype wire

// ===== rtl/rv32im_execute_alu.sv =====
// rv32im_execute_alu: pipelined RV32IM execute unit, top level
`default_nettype none
// Takes one operation in every cycle (busy stays low) and returns its result
// through the operand, product, divider and output registers on rsp_result,
// with rsp_strobe high for one cycle; results leave in the order the operations
// came in. The divider, which sets the latency, resolves one quotient bit per
// pipeline stage over 32 stages; every other operation travels the same path
// so that the order is kept. The receiver cannot stall the unit.
module rv32im_execute_alu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire rvalu_pkg::mode_type req_mode,
   input  wire rvalu_pkg::word_type req_operand_a,
   input  wire rvalu_pkg::word_type req_operand_b,
   output logic                     rsp_strobe,
   output rvalu_pkg::word_type      rsp_result
);
   import rvalu_pkg::*;

   // stage 1: operands and 16 x 16 partial products
   logic     s1_valid_ff;
   mode_type s1_mode_ff;
   word_type s1_a_ff, s1_b_ff;
   word_type s1_pp_ll_ff, s1_pp_lh_ff, s1_pp_hl_ff, s1_pp_hh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_mode_ff  <= req_mode;
      s1_a_ff     <= req_operand_a;
      s1_b_ff     <= req_operand_b;
      s1_pp_ll_ff <= req_operand_a[15:0]  * req_operand_b[15:0];
      s1_pp_lh_ff <= req_operand_a[15:0]  * req_operand_b[31:16];
      s1_pp_hl_ff <= req_operand_a[31:16] * req_operand_b[15:0];
      s1_pp_hh_ff <= req_operand_a[31:16] * req_operand_b[31:16];
   end

   // stage 2: unsigned product and the simple operations
   logic        s2_valid_ff;
   mode_type    s2_mode_ff;
   word_type    s2_a_ff, s2_b_ff;
   logic [63:0] s2_prod_ff, s2_prod_in;
   word_type    s2_alu_ff, s2_alu_in;
   logic [4:0]  shamt;

   always_comb begin
      shamt      = s1_b_ff[4:0];
      s2_prod_in = {s1_pp_hh_ff, 32'd0}
                 + {16'd0, s1_pp_lh_ff, 16'd0}
                 + {16'd0, s1_pp_hl_ff, 16'd0}
                 + {32'd0, s1_pp_ll_ff};
      case (s1_mode_ff)
         MODE_ADD:  s2_alu_in = s1_a_ff + s1_b_ff;
         MODE_SUB:  s2_alu_in = s1_a_ff - s1_b_ff;
         MODE_SLL:  s2_alu_in = s1_a_ff << shamt;
         MODE_SLT:  s2_alu_in = {31'd0, $signed(s1_a_ff) < $signed(s1_b_ff)};
         MODE_SLTU: s2_alu_in = {31'd0, s1_a_ff < s1_b_ff};
         MODE_XOR:  s2_alu_in = s1_a_ff ^ s1_b_ff;
         MODE_SRL:  s2_alu_in = s1_a_ff >> shamt;
         MODE_SRA:  s2_alu_in = word_type'($signed(s1_a_ff) >>> shamt);
         MODE_OR:   s2_alu_in = s1_a_ff | s1_b_ff;
         MODE_AND:  s2_alu_in = s1_a_ff & s1_b_ff;
         default:   s2_alu_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mode_ff <= s1_mode_ff;
      s2_a_ff    <= s1_a_ff;
      s2_b_ff    <= s1_b_ff;
      s2_prod_ff <= s2_prod_in;
      s2_alu_ff  <= s2_alu_in;
   end

   // stage 3: signed product correction, divider operands and special cases
   word_type    corr_a, corr_b, mag_a, mag_b;
   logic        is_signed_div, a_neg, b_neg, b_zero, overflow;
   div_tag_type tag_in;

   always_comb begin
      corr_a        = s2_a_ff[XLEN-1] ? s2_b_ff : '0;
      corr_b        = s2_b_ff[XLEN-1] ? s2_a_ff : '0;
      is_signed_div = (s2_mode_ff == MODE_DIV) || (s2_mode_ff == MODE_REM);
      a_neg         = is_signed_div && s2_a_ff[XLEN-1];
      b_neg         = is_signed_div && s2_b_ff[XLEN-1];
      mag_a         = a_neg ? (XLEN'(0) - s2_a_ff) : s2_a_ff;
      mag_b         = b_neg ? (XLEN'(0) - s2_b_ff) : s2_b_ff;
      b_zero        = (s2_b_ff == '0);
      overflow      = (s2_a_ff == SIGN_BIT) && (s2_b_ff == WORD_ONES);

      tag_in.mode  = s2_mode_ff;
      tag_in.neg_q = a_neg ^ b_neg;
      tag_in.neg_r = a_neg;
      tag_in.spec  = is_signed_div && (b_zero || overflow);
      if (b_zero) begin
         tag_in.spec_val = (s2_mode_ff == MODE_DIV) ? WORD_ONES : s2_a_ff;
      end else begin
         tag_in.spec_val = (s2_mode_ff == MODE_DIV) ? SIGN_BIT : '0;
      end
      case (s2_mode_ff)
         MODE_MUL:    tag_in.side = s2_prod_ff[31:0];
         MODE_MULH:   tag_in.side = s2_prod_ff[63:32] - corr_a - corr_b;
         MODE_MULHSU: tag_in.side = s2_prod_ff[63:32] - corr_a;
         MODE_MULHU:  tag_in.side = s2_prod_ff[63:32];
         default:     tag_in.side = s2_alu_ff;
      endcase
   end

   // divider pipeline, every item passes through it
   logic        dv_valid;
   word_type    dv_q, dv_r;
   div_tag_type dv_tag;

   rvalu_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_n      (mag_a),
      .in_d      (mag_b),
      .in_tag    (tag_in),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_r     (dv_r),
      .out_tag   (dv_tag)
   );

   // output stage: sign fix-up and result select
   logic     rsp_strobe_ff;
   word_type rsp_result_ff, rsp_result_in;

   always_comb begin
      case (dv_tag.mode)
         MODE_DIV: begin
            if (dv_tag.spec) rsp_result_in = dv_tag.spec_val;
            else             rsp_result_in = dv_tag.neg_q ? (XLEN'(0) - dv_q) : dv_q;
         end
         MODE_REM: begin
            if (dv_tag.spec) rsp_result_in = dv_tag.spec_val;
            else             rsp_result_in = dv_tag.neg_r ? (XLEN'(0) - dv_r) : dv_r;
         end
         MODE_DIVU: rsp_result_in = dv_q;
         MODE_REMU: rsp_result_in = dv_r;
         default:   rsp_result_in = dv_tag.side;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result = rsp_result_ff;

endmodule
`default_nettype wire

// ===== rtl/rvalu_divider.sv =====
// rvalu_divider: unsigned restoring divider, one quotient bit per pipeline stage
`default_nettype none
module rvalu_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire rvalu_pkg::word_type in_n,
   input  wire rvalu_pkg::word_type in_d,
   input  wire rvalu_pkg::div_tag_type in_tag,
   output logic                     out_valid,
   output rvalu_pkg::word_type      out_q,
   output rvalu_pkg::word_type      out_r,
   output rvalu_pkg::div_tag_type   out_tag
);
   import rvalu_pkg::*;

   logic         valid_ff [0:DIV_STEPS];
   div_work_type work_ff  [0:DIV_STEPS];
   div_tag_type  tag_ff   [0:DIV_STEPS];

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      work_ff[0].n <= in_n;
      work_ff[0].r <= '0;
      work_ff[0].d <= in_d;
      tag_ff[0]    <= in_tag;
   end

   // one shift, trial subtract and restore per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [XLEN:0] shifted;
      logic [XLEN:0] diff;
      div_work_type  work_in;

      always_comb begin
         shifted   = {work_ff[k].r, work_ff[k].n[XLEN-1]};
         diff      = shifted - {1'b0, work_ff[k].d};
         work_in.d = work_ff[k].d;
         work_in.r = diff[XLEN] ? shifted[XLEN-1:0] : diff[XLEN-1:0];
         work_in.n = {work_ff[k].n[XLEN-2:0], ~diff[XLEN]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         work_ff[k+1] <= work_in;
         tag_ff[k+1]  <= tag_ff[k];
      end
   end

   assign out_valid = valid_ff[DIV_STEPS];
   assign out_q     = work_ff[DIV_STEPS].n;
   assign out_r     = work_ff[DIV_STEPS].r;
   assign out_tag   = tag_ff[DIV_STEPS];

endmodule
`default_nettype wire

// ===== rtl/rvalu_checker.sv =====
// rvalu_checker: port-level checks of the execute unit and its bind
`default_nettype none
module rvalu_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire rvalu_pkg::mode_type req_mode,
   input wire rvalu_pkg::word_type req_operand_a,
   input wire rvalu_pkg::word_type req_operand_b,
   input wire logic                rsp_strobe,
   input wire rvalu_pkg::word_type rsp_result
);
   import rvalu_pkg::*;

   // the unit never holds off a transfer
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every result has a matching earlier transfer
   a_strobe_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without matching request");

   // add result arrives intact
   a_add_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_mode, LATENCY) == MODE_ADD |->
      rsp_result == $past(req_operand_a, LATENCY) + $past(req_operand_b, LATENCY))
      else $error("add result wrong");

   // unsigned divide by zero gives all ones
   a_divu_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_mode, LATENCY) == MODE_DIVU
      && $past(req_operand_b, LATENCY) == '0 |-> rsp_result == WORD_ONES)
      else $error("divu by zero wrong");

endmodule

bind rv32im_execute_alu rvalu_checker u_rvalu_checker (.*);
`default_nettype wire
